// File: src/pam_pkg.sv
// Shared types and constants for the position automaton matcher.
// Holds opcodes, configuration register indexes, queue entry and result types.
// No dependencies.
`default_nettype none

package pam_pkg;

  // Default sizes of the automaton
  localparam int POSITIONS_DEFAULT = 32;
  localparam int ALPHABET_DEFAULT  = 256;

  // Depth of the queues between front, back and result port
  localparam int QUEUE_DEPTH = 2;

  // Field and register widths
  localparam int OPCODE_W  = 2;
  localparam int SYMBOL_W  = 8;
  localparam int ROW_IDX_W = 5;
  localparam int ROW_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Item opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_RESTART = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_MASK_WR = 2'd2,
    OP_ROW_WR  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POSITIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_POSITIONS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPTS_EMPTY   = 2'd2;

  // Control part of a word between front and back
  typedef struct packed {
    op_t                  op;
    logic [ROW_IDX_W-1:0] row_index;
  } cmd_ctl_t;

  // One result word
  typedef struct packed {
    logic accepting;
    logic stuck;
  } res_t;

endpackage

`default_nettype wire

// File: src/pam_fifo.sv
// Small register queue used between the front and back and on the result side.
// Standalone; no package dependency.
`default_nettype none

module pam_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold stored words
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: src/pam_front.sv
// Front end: takes input words, owns the symbol mask table and classifies items.
// Depends on pam_pkg.
`default_nettype none

module pam_front #(
  parameter int POSITIONS = pam_pkg::POSITIONS_DEFAULT,
  parameter int ALPHABET  = pam_pkg::ALPHABET_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [pam_pkg::OPCODE_W-1:0]     opcode,
  input  logic [pam_pkg::SYMBOL_W-1:0]     symbol,
  input  logic [pam_pkg::ROW_IDX_W-1:0]    row_index,
  input  logic [pam_pkg::ROW_W-1:0]        row_bits,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pam_pkg::cmd_ctl_t                out_ctl,
  output logic [POSITIONS-1:0]             out_data
);

  import pam_pkg::*;

  localparam int AW = $clog2(ALPHABET);
  localparam logic [SYMBOL_W:0] ALPHA_LIM = (SYMBOL_W + 1)'(ALPHABET);

  logic [POSITIONS-1:0] mask_mem [ALPHABET];
  logic [ALPHABET-1:0]  mask_valid;

  logic                 take;
  logic                 sym_ok;
  logic [AW-1:0]        sym_addr;
  logic [63:0]          bits_ext;
  logic [POSITIONS-1:0] bits_fit;
  op_t                  op_in;

  logic                 valid;
  cmd_ctl_t             ctl_q;
  logic [POSITIONS-1:0] bits_q;
  logic [POSITIONS-1:0] mask_q;
  logic                 hit_q;

  assign take     = push && !full;
  assign op_in    = op_t'(opcode);
  assign sym_ok   = ({1'b0, symbol} < ALPHA_LIM);
  assign sym_addr = symbol[AW-1:0];
  assign bits_ext = {32'b0, row_bits};
  assign bits_fit = bits_ext[POSITIONS-1:0];

  assign full      = valid && !out_ready;
  assign out_valid = valid;
  assign out_ctl   = ctl_q;
  // An advance carries its symbol mask, a row write its row bits
  assign out_data  = (ctl_q.op == OP_ADVANCE) ? (hit_q ? mask_q : '0) : bits_q;

  // Hold the staged word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  // Capture payload and the mask entry flag
  always_ff @(posedge clk) begin
    if (take) begin
      ctl_q.op        <= op_in;
      ctl_q.row_index <= row_index;
      bits_q          <= bits_fit;
      hit_q           <= sym_ok && mask_valid[sym_addr];
    end
  end

  // Mark written mask entries; unwritten ones read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= '0;
    end else if (take && op_in == OP_MASK_WR && sym_ok) begin
      mask_valid[sym_addr] <= 1'b1;
    end
  end

  // Symbol mask table: one write, one registered read
  always_ff @(posedge clk) begin
    if (take) begin
      mask_q <= mask_mem[sym_addr];
      if (op_in == OP_MASK_WR && sym_ok) begin
        mask_mem[sym_addr] <= bits_fit;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/pam_back.sv
// Back end: active position set, follow matrix and the step update.
// Depends on pam_pkg.
`default_nettype none

module pam_back #(
  parameter int POSITIONS = pam_pkg::POSITIONS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  pam_pkg::cmd_ctl_t    cmd_ctl,
  input  logic [POSITIONS-1:0] cmd_data,
  output logic                 cmd_take,
  input  logic [POSITIONS-1:0] first_positions,
  input  logic [POSITIONS-1:0] last_positions,
  input  logic                 accepts_empty,
  input  logic                 res_ready,
  output pam_pkg::res_t        res
);

  import pam_pkg::*;

  logic [POSITIONS-1:0] follow_rows [POSITIONS];
  logic [POSITIONS-1:0] active;
  logic                 accept_flag;

  logic [POSITIONS-1:0] live;
  logic [POSITIONS-1:0] image;
  logic [POSITIONS-1:0] active_next;
  logic                 accept_flag_next;

  assign cmd_take = cmd_valid && res_ready;
  assign live     = active & cmd_data;

  // OR together the follow rows of the surviving positions
  always_comb begin
    image = '0;
    for (int i = 0; i < POSITIONS; i++) begin
      if (live[i]) begin
        image = image | follow_rows[i];
      end
    end
  end

  // Step update by opcode
  always_comb begin
    active_next      = active;
    accept_flag_next = accept_flag;
    case (cmd_ctl.op)
      OP_RESTART: begin
        active_next      = first_positions;
        accept_flag_next = accepts_empty;
      end
      OP_ADVANCE: begin
        active_next      = image;
        accept_flag_next = |(live & last_positions);
      end
      default: begin
      end
    endcase
  end

  assign res.accepting = accept_flag_next;
  assign res.stuck     = (active_next == '0);

  // Advance the active set
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      accept_flag <= 1'b0;
    end else if (cmd_take) begin
      active      <= active_next;
      accept_flag <= accept_flag_next;
    end
  end

  // Follow matrix rows, cleared at reset
  for (genvar r = 0; r < POSITIONS; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (rst) begin
        follow_rows[r] <= '0;
      end else if (cmd_take && cmd_ctl.op == OP_ROW_WR &&
                   {1'b0, cmd_ctl.row_index} == (ROW_IDX_W + 1)'(r)) begin
        follow_rows[r] <= cmd_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/position_automaton_matcher.sv
// Position automaton matcher, top level: config registers, front, queues, back.
// Path: an item passes the front stage register, the command queue, the back end and the result queue.
// Throughput: one item per cycle while the queues have room; the back end's follow-row OR is combinational.
// Reset: synchronous rst clears registers, the active set, the follow matrix and
// the mask table valid bits; both queues come up empty. Depends on pam_pkg.
`default_nettype none

module position_automaton_matcher #(
  parameter int POSITIONS = pam_pkg::POSITIONS_DEFAULT,
  parameter int ALPHABET  = pam_pkg::ALPHABET_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pam_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [pam_pkg::OPCODE_W-1:0]   opcode,
  input  logic [pam_pkg::SYMBOL_W-1:0]   symbol,
  input  logic [pam_pkg::ROW_IDX_W-1:0]  row_index,
  input  logic [pam_pkg::ROW_W-1:0]      row_bits,
  output logic                           empty,
  input  logic                           pop,
  output logic                           accepting,
  output logic                           stuck
);

  import pam_pkg::*;

  localparam int CTL_W   = $bits(cmd_ctl_t);
  localparam int ENTRY_W = CTL_W + POSITIONS;
  localparam int RES_W   = $bits(res_t);

  logic [POSITIONS-1:0] first_positions;
  logic [POSITIONS-1:0] last_positions;
  logic                 accepts_empty;
  logic [63:0]          cfg_ext;

  logic                 fr_valid;
  cmd_ctl_t             fr_ctl;
  logic [POSITIONS-1:0] fr_data;
  logic                 cmd_full;
  logic                 cmd_empty;
  logic [ENTRY_W-1:0]   cmd_rdata;
  cmd_ctl_t             cmd_ctl;
  logic [POSITIONS-1:0] cmd_data;
  logic                 cmd_take;
  logic                 res_full;
  res_t                 res_in;
  res_t                 res_out;

  assign cfg_ext = {32'b0, cfg_data};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_positions <= '0;
      last_positions  <= '0;
      accepts_empty   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FIRST_POSITIONS: first_positions <= cfg_ext[POSITIONS-1:0];
        CFG_LAST_POSITIONS:  last_positions  <= cfg_ext[POSITIONS-1:0];
        CFG_ACCEPTS_EMPTY:   accepts_empty   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pam_front #(
    .POSITIONS (POSITIONS),
    .ALPHABET  (ALPHABET)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .symbol    (symbol),
    .row_index (row_index),
    .row_bits  (row_bits),
    .out_valid (fr_valid),
    .out_ready (!cmd_full),
    .out_ctl   (fr_ctl),
    .out_data  (fr_data)
  );

  pam_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_valid),
    .pop   (cmd_take),
    .wdata ({fr_ctl, fr_data}),
    .full  (cmd_full),
    .empty (cmd_empty),
    .rdata (cmd_rdata)
  );

  assign cmd_ctl  = cmd_ctl_t'(cmd_rdata[ENTRY_W-1:POSITIONS]);
  assign cmd_data = cmd_rdata[POSITIONS-1:0];

  pam_back #(
    .POSITIONS (POSITIONS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (!cmd_empty),
    .cmd_ctl         (cmd_ctl),
    .cmd_data        (cmd_data),
    .cmd_take        (cmd_take),
    .first_positions (first_positions),
    .last_positions  (last_positions),
    .accepts_empty   (accepts_empty),
    .res_ready       (!res_full),
    .res             (res_in)
  );

  pam_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_take),
    .pop   (pop),
    .wdata (res_in),
    .full  (res_full),
    .empty (empty),
    .rdata (res_out)
  );

  assign accepting = res_out.accepting;
  assign stuck     = res_out.stuck;

  // Both sides come out of reset open for input and with nothing to deliver
  a_reset_state: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queue state wrong after reset");

  // Back pressure on input only comes from a staged front word
  a_full_source: assert property (@(posedge clk) disable iff (rst) full |-> fr_valid)
    else $error("full raised with no staged word");

  // An accepted word is staged on the next cycle
  a_take_staged: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> fr_valid)
    else $error("accepted word not staged");

  // The back end never runs without a queued word and room for its result
  a_back_fire: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (!cmd_empty && !res_full))
    else $error("back end stepped without word or room");

endmodule

`default_nettype wire
